// ===== sv/tbn_pkg.sv =====
// Shared types, constants and helpers for the touch baseline normalizer.
package tbn_pkg;

   // Configuration register indexes and their reset values.
   localparam logic [1:0] CSR_START_SPAN  = 2'd0;
   localparam logic [1:0] CSR_FLOOR_STEP  = 2'd1;
   localparam logic [1:0] CSR_DRIFT_DELAY = 2'd2;

   localparam logic [15:0] START_SPAN_RESET  = 16'd256;
   localparam logic [15:0] FLOOR_STEP_RESET  = 16'd1;
   localparam logic [15:0] DRIFT_DELAY_RESET = 16'd500;

   // Full-scale touch level; quotients above it are clamped.
   localparam logic [7:0] TOUCH_FULL_SCALE = 8'd255;

   // Number of quotient bits produced by the bit-serial divider.
   localparam int unsigned DIV_STEPS = 8;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_PREP,
      ST_CHECK,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic update;
      logic prep;
      logic check;
      logic step;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
   } status_type;

   // Add two 16-bit levels and saturate at the top of the range.
   function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

endpackage

// ===== sv/tbn_ctrl.sv =====
// Controller state machine and result-valid register for the touch normalizer.
module tbn_ctrl
   import tbn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new value when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid is set by a finished request and cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // A result must never overwrite one that is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free)
      else $error("result register overwritten while stalled");

   // An accepted request always starts the floor update next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_UPDATE))
      else $error("accepted request did not start processing");

   // The last divider step hands over to the result stage.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && status.div_done) |=> (state_ff == ST_DONE))
      else $error("divider completion not followed by result stage");

   // A new result only appears after a finish command.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("result valid rose without a finished request");

endmodule

// ===== sv/tbn_dp.sv =====
// Datapath: configuration, floor/ceiling tracking, bit-serial divider, result register.
module tbn_dp
   import tbn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic [15:0] req_time_req,
   input  logic [15:0] req_raw_count,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [7:0]  rsp_touch_level,
   output logic [11:0] rsp_raw_scaled
);

   // Configuration registers.
   logic [15:0] start_span_ff, floor_step_ff, drift_delay_ff;
   // Tracking state.
   logic [15:0] floor_ff, floor_in;
   logic [15:0] ceil_ff, ceil_in;
   logic [15:0] stamp_ff, stamp_in;
   // Captured request.
   logic [15:0] time_ff, raw_ff;
   // Divider operands and working registers.
   logic [23:0] num_ff;
   logic [15:0] den_ff;
   logic        zero_ff, sat_ff;
   logic [15:0] rem_ff;
   logic [7:0]  low_ff;
   logic [7:0]  quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   // Result register.
   logic [7:0]  level_ff;
   logic [11:0] scaled_ff;

   logic [15:0] elapsed;
   logic [15:0] diff;
   logic [16:0] trial;
   logic        trial_ge;
   logic [16:0] trial_sub;
   logic [7:0]  level_in;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_span_ff  <= START_SPAN_RESET;
         floor_step_ff  <= FLOOR_STEP_RESET;
         drift_delay_ff <= DRIFT_DELAY_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_START_SPAN:  start_span_ff  <= csr_wdata;
            CSR_FLOOR_STEP:  floor_step_ff  <= csr_wdata;
            CSR_DRIFT_DELAY: drift_delay_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Floor, ceiling and stamp update for one sample.
   assign elapsed = time_ff - stamp_ff;

   always_comb begin
      floor_in = floor_ff;
      ceil_in  = ceil_ff;
      stamp_in = stamp_ff;
      if (floor_ff == 16'd0) begin
         floor_in = raw_ff;
         ceil_in  = sat_add16(raw_ff, start_span_ff);
      end else begin
         if (raw_ff <= floor_ff) begin
            floor_in = raw_ff;
            stamp_in = time_ff;
         end else if (elapsed > drift_delay_ff) begin
            floor_in = sat_add16(floor_ff, floor_step_ff);
            stamp_in = time_ff;
         end
         if (raw_ff > ceil_ff) begin
            ceil_in = raw_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= '0;
         ceil_ff  <= '0;
         stamp_ff <= '0;
      end else if (cmd.update) begin
         floor_ff <= floor_in;
         ceil_ff  <= ceil_in;
         stamp_ff <= stamp_in;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         time_ff <= req_time_req;
         raw_ff  <= req_raw_count;
      end
   end

   // Numerator is (raw - floor) * 255, formed as a shift and a subtract.
   assign diff = raw_ff - floor_ff;

   // One restoring division step on the remainder and next numerator bit.
   assign trial     = {rem_ff, low_ff[7]};
   assign trial_ge  = (trial >= {1'b0, den_ff});
   assign trial_sub = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         num_ff  <= {diff, 8'd0} - {8'd0, diff};
         den_ff  <= ceil_ff - floor_ff;
         zero_ff <= !((raw_ff > floor_ff) && (ceil_ff > floor_ff));
      end
      if (cmd.check) begin
         // A quotient of 256 or more clamps; otherwise the top bits fit below den.
         sat_ff <= (num_ff >= {den_ff, 8'd0});
         rem_ff <= num_ff[23:8];
         low_ff <= num_ff[7:0];
         quo_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.step) begin
         rem_ff <= trial_ge ? trial_sub[15:0] : trial[15:0];
         low_ff <= {low_ff[6:0], 1'b0};
         quo_ff <= {quo_ff[6:0], trial_ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign status.div_done = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // Final level selection and result register.
   always_comb begin
      priority if (zero_ff) begin
         level_in = '0;
      end else if (sat_ff) begin
         level_in = TOUCH_FULL_SCALE;
      end else begin
         level_in = quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         level_ff  <= level_in;
         scaled_ff <= raw_ff[15:4];
      end
   end

   assign rsp_touch_level = level_ff;
   assign rsp_raw_scaled  = scaled_ff;

endmodule

// ===== sv/touch_baseline_normalizer.sv =====
// Top level of the capacitive touch baseline normalizer.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    req_time_req[15:0], req_raw_count[15:0]
//   rsp      out        rsp_valid/stall    rsp_touch_level[7:0], rsp_raw_scaled[11:0]
//   csr      in         csr_valid/ready    csr_index[1:0], csr_wdata[15:0]
//
// Each request runs from acceptance to the next acceptance through a floor and
// ceiling update, numerator setup, a clamp check, eight restoring divider steps, the
// result stage and the idle state in which the next request is accepted.
// A new request is accepted while the previous result still waits in the output
// register; a stalled result only holds the request in its final stage.
// Reset clears floor, ceiling and stamp and restores the defaults; csr is always ready.
module touch_baseline_normalizer
   import tbn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_time_req,
   input  logic [15:0] req_raw_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_touch_level,
   output logic [11:0] rsp_raw_scaled,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // Sequencing of one request at a time.
   tbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Tracking state, divider and result register.
   tbn_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_time_req    (req_time_req),
      .req_raw_count   (req_raw_count),
      .cmd             (cmd),
      .status          (status),
      .rsp_touch_level (rsp_touch_level),
      .rsp_raw_scaled  (rsp_raw_scaled)
   );

endmodule
